### hdl/cwc_pkg.sv
package cwc_pkg;

  localparam int SEQ_BITS_DEF = 20;
  localparam int WIN_W        = 17;
  localparam int CA_W         = 19;
  localparam int CA_INC_W     = 10;
  localparam int BYTES_W      = 10;
  localparam int ID_W         = 16;
  localparam int CFG_IDX_W    = 3;

  localparam int MSS          = 512;
  localparam int WIN_LIMIT    = 65536;
  localparam int CA_NUM       = 512 * 512;
  localparam int SEQ_MOD_RST  = 102401;
  localparam int SSTH_RST     = 10000;
  localparam int MAXW_RST     = 51200;

  localparam logic [1:0] FUNC_SEND    = 2'd0;
  localparam logic [1:0] FUNC_ACK     = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODULUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SEQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONN_ID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SSTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW  = 3'd4;

  // operand routed through the shared divider
  typedef enum logic [2:0] {
    SEL_SEND,
    SEL_ACKED,
    SEL_HIGH,
    SEL_ACKN,
    SEL_INFL,
    SEL_END,
    SEL_CA,
    SEL_START
  } sel_t;

  typedef struct packed {
    logic latch;
    logic div_start;
    sel_t div_sel;
    logic clr_norm;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       div_busy;
    logic [1:0] func;
    logic       id_ok;
    logic       win_open;
    logic       ack_in_win;
    logic       slow_start;
    logic       norm_pending;
    logic       start_pending;
    logic       out_free;
  } status_t;

  function automatic logic [WIN_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    r = v;
    if (v < WIN_W'(MSS)) r = WIN_W'(MSS);
    if (v > WIN_W'(WIN_LIMIT)) r = WIN_W'(WIN_LIMIT);
    return r;
  endfunction

endpackage

### hdl/tcp_congestion_window_ctrl.sv
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    func, seg_bytes, ack_number, peer_conn_id
// out      out  out_valid/out_stall  may_send, seg_seq, seg_is_retransmit, ack_accepted,
//                                    conn_error, cwnd_now, ssthresh_now, in_flight_now
// cfg      in   cfg_we               cfg_index, cfg_data
//
// one request at a time; every modulo and the avoidance quotient share one restoring
// divider, which skips the shift loop when the operand is below the divisor
// a refused send, wrong id or no event goes straight to the update; send, ack and
// timeout each run one reduction, an in-window ack in avoidance also the quotient;
// the first request after a seq_modulus write adds three reductions, after start_seq four
// synchronous reset, no clearing pass; a stalled result is held in the output
// register while the next request is already being worked on
module tcp_congestion_window_ctrl
  import cwc_pkg::*;
#(
  parameter int SEQ_BITS = SEQ_BITS_DEF,
  parameter int CFG_W    = ((SEQ_BITS + 1) > WIN_W) ? (SEQ_BITS + 1) : WIN_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           func,
  input  logic [BYTES_W-1:0]   seg_bytes,
  input  logic [SEQ_BITS-1:0]  ack_number,
  input  logic [ID_W-1:0]      peer_conn_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 may_send,
  output logic [SEQ_BITS-1:0]  seg_seq,
  output logic                 seg_is_retransmit,
  output logic                 ack_accepted,
  output logic                 conn_error,
  output logic [WIN_W-1:0]     cwnd_now,
  output logic [WIN_W-1:0]     ssthresh_now,
  output logic [WIN_W-1:0]     in_flight_now
);

  cmd_t    cmd;
  status_t stat;

  cwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cwc_datapath #(
    .SEQ_BITS (SEQ_BITS),
    .CFG_W    (CFG_W)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .func              (func),
    .seg_bytes         (seg_bytes),
    .ack_number        (ack_number),
    .peer_conn_id      (peer_conn_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .may_send          (may_send),
    .seg_seq           (seg_seq),
    .seg_is_retransmit (seg_is_retransmit),
    .ack_accepted      (ack_accepted),
    .conn_error        (conn_error),
    .cwnd_now          (cwnd_now),
    .ssthresh_now      (ssthresh_now),
    .in_flight_now     (in_flight_now)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a held result");

  a_accept_div_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !stat.div_busy)
    else $error("request accepted while divider busy");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> (!stat.div_busy && !stat.div_done))
    else $error("divider restarted while busy");

  a_cwnd_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cwnd_now >= WIN_W'(MSS)))
    else $error("congestion window below one segment");

endmodule

### hdl/cwc_divider.sv
module cwc_divider
  import cwc_pkg::*;
#(
  parameter int NW = 21,
  parameter int DW = 21
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int XW    = (NW > DW) ? NW : DW;
  localparam int CNT_W = $clog2(NW + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    num_sh;
  logic [DW-1:0]    den_r;
  logic [DW:0]      r2;
  logic [DW:0]      r2_sub;
  logic             ge;
  logic             num_lt_den;

  assign num_lt_den = XW'(num) < XW'(den);
  assign r2         = {rem, num_sh[NW-1]};
  assign ge         = r2 >= {1'b0, den_r};
  assign r2_sub     = r2 - {1'b0, den_r};
  assign busy       = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num_lt_den) begin
          done <= 1'b1;
        end else begin
          run <= 1'b1;
          cnt <= CNT_W'(NW);
        end
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den;
      num_sh <= num;
      quo    <= '0;
      rem    <= num_lt_den ? DW'(num) : '0;
    end else if (run) begin
      num_sh <= num_sh << 1;
      quo    <= {quo[NW-2:0], ge};
      rem    <= ge ? r2_sub[DW-1:0] : r2[DW-1:0];
    end
  end

endmodule

### hdl/cwc_datapath.sv
module cwc_datapath
  import cwc_pkg::*;
#(
  parameter int SEQ_BITS = SEQ_BITS_DEF,
  parameter int CFG_W    = 21
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [1:0]           func,
  input  logic [BYTES_W-1:0]   seg_bytes,
  input  logic [SEQ_BITS-1:0]  ack_number,
  input  logic [ID_W-1:0]      peer_conn_id,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 may_send,
  output logic [SEQ_BITS-1:0]  seg_seq,
  output logic                 seg_is_retransmit,
  output logic                 ack_accepted,
  output logic                 conn_error,
  output logic [WIN_W-1:0]     cwnd_now,
  output logic [WIN_W-1:0]     ssthresh_now,
  output logic [WIN_W-1:0]     in_flight_now
);

  localparam int MW = SEQ_BITS + 1;
  localparam int NW = (MW > CA_W) ? MW : CA_W;
  localparam int DW = (MW > WIN_W) ? MW : WIN_W;
  localparam int CW = (SEQ_BITS > WIN_W) ? SEQ_BITS : WIN_W;
  localparam logic [MW-1:0] SEQ_TOP = {1'b1, {SEQ_BITS{1'b0}}};

  // configuration
  logic [MW-1:0]       seq_modulus;
  logic [ID_W-1:0]     expected_conn_id;
  logic [WIN_W-1:0]    max_window;

  // connection state
  logic [WIN_W-1:0]    cwnd;
  logic [WIN_W-1:0]    ssthresh;
  logic [WIN_W-1:0]    in_flight;
  logic [SEQ_BITS-1:0] send_seq;
  logic [SEQ_BITS-1:0] acked_seq;
  logic [SEQ_BITS-1:0] highest_seq;
  logic                norm_pending;
  // modulus in force when start_seq was written
  logic [MW-1:0]       start_m;
  logic                start_pending;

  // current request
  logic [1:0]          func_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [SEQ_BITS-1:0] ack_r;
  logic                id_ok_r;
  logic [SEQ_BITS-1:0] infl_mod;
  logic [SEQ_BITS-1:0] end_r;
  logic [CA_INC_W-1:0] ca_inc;
  sel_t                sel_r;

  // per-event flags
  logic [SEQ_BITS-1:0] seg_seq_r;
  logic                retx_r;
  logic                acc_r;
  logic                cerr_r;

  logic [MW-1:0]       eff_m;
  logic [WIN_W-1:0]    maxw;
  logic [SEQ_BITS-1:0] ds;
  logic [SEQ_BITS-1:0] dh;
  logic [SEQ_BITS-1:0] da;
  logic                in_win;
  logic                win_open;
  logic                slow_start;
  logic [WIN_W:0]      grown;
  logic [WIN_W-1:0]    cwnd_grown;
  logic [WIN_W:0]      infl_sum;
  logic [WIN_W-1:0]    infl_add;
  logic [CW-1:0]       infl_diff;
  logic [WIN_W-1:0]    infl_sub;
  logic [MW-1:0]       rew;
  logic [SEQ_BITS-1:0] send_rew;
  logic                high_move;
  logic [BYTES_W-1:0]  bytes_clamped;

  logic                div_done;
  logic                div_busy;
  logic [NW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic [NW-1:0]       div_quo;
  logic [DW-1:0]       div_rem;

  function automatic logic [SEQ_BITS-1:0] mdist(input logic [SEQ_BITS-1:0] a,
                                                input logic [SEQ_BITS-1:0] b,
                                                input logic [MW-1:0] m);
    logic [MW-1:0] d;
    d = MW'(b) - MW'(a);
    if (b < a) d = d + m;
    return d[SEQ_BITS-1:0];
  endfunction

  always_comb begin
    eff_m = seq_modulus;
    if (seq_modulus < MW'(2)) eff_m = MW'(2);
    if (seq_modulus > SEQ_TOP) eff_m = SEQ_TOP;
  end

  assign maxw       = clamp_win(max_window);
  assign ds         = mdist(acked_seq, send_seq, eff_m);
  assign dh         = mdist(acked_seq, highest_seq, eff_m);
  assign da         = mdist(acked_seq, ack_r, eff_m);
  assign in_win     = (da != '0) && (da <= dh);
  assign win_open   = ({1'b0, in_flight} + (WIN_W+1)'(MSS)) <= {1'b0, cwnd};
  assign slow_start = cwnd < ssthresh;

  assign grown      = {1'b0, cwnd} + (slow_start ? (WIN_W+1)'(MSS) : (WIN_W+1)'(ca_inc));
  assign cwnd_grown = (grown > {1'b0, maxw}) ? maxw : grown[WIN_W-1:0];

  assign infl_sum   = {1'b0, in_flight} + (WIN_W+1)'(bytes_r);
  assign infl_add   = (infl_sum > (WIN_W+1)'(WIN_LIMIT)) ? WIN_W'(WIN_LIMIT)
                                                        : infl_sum[WIN_W-1:0];
  assign infl_diff  = CW'(in_flight) - CW'(da);
  assign infl_sub   = (CW'(da) >= CW'(in_flight)) ? '0 : infl_diff[WIN_W-1:0];

  assign high_move  = (NW'(ds) + NW'(bytes_r)) > NW'(dh);

  always_comb begin
    rew = MW'(send_seq) - MW'(infl_mod);
    if (send_seq < infl_mod) rew = rew + eff_m;
  end
  assign send_rew = rew[SEQ_BITS-1:0];

  assign bytes_clamped = (seg_bytes > BYTES_W'(MSS)) ? BYTES_W'(MSS) : seg_bytes;

  always_comb begin
    div_den = DW'(eff_m);
    case (cmd.div_sel)
      SEL_SEND:  div_num = NW'(send_seq);
      SEL_ACKED: div_num = NW'(acked_seq);
      SEL_HIGH:  div_num = NW'(highest_seq);
      SEL_ACKN:  div_num = NW'(ack_r);
      SEL_INFL:  div_num = NW'(in_flight);
      SEL_END:   div_num = NW'(send_seq) + NW'(bytes_r);
      SEL_CA: begin
        div_num = NW'(CA_NUM);
        div_den = DW'(cwnd);
      end
      SEL_START: begin
        div_num = NW'(send_seq);
        div_den = DW'(start_m);
      end
      default:   div_num = '0;
    endcase
  end

  cwc_divider #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // connection state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_modulus      <= MW'(SEQ_MOD_RST);
      expected_conn_id <= '0;
      max_window       <= WIN_W'(MAXW_RST);
      cwnd             <= WIN_W'(MSS);
      ssthresh         <= clamp_win(WIN_W'(SSTH_RST));
      in_flight        <= '0;
      send_seq         <= '0;
      acked_seq        <= '0;
      highest_seq      <= '0;
      norm_pending     <= 1'b0;
      start_m          <= MW'(SEQ_MOD_RST);
      start_pending    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEQ_MODULUS: begin
          seq_modulus  <= cfg_data[MW-1:0];
          norm_pending <= 1'b1;
        end
        REG_START_SEQ: begin
          send_seq      <= cfg_data[SEQ_BITS-1:0];
          acked_seq     <= cfg_data[SEQ_BITS-1:0];
          highest_seq   <= cfg_data[SEQ_BITS-1:0];
          norm_pending  <= 1'b1;
          start_m       <= eff_m;
          start_pending <= 1'b1;
        end
        REG_CONN_ID:    expected_conn_id <= cfg_data[ID_W-1:0];
        REG_INIT_SSTH:  ssthresh <= clamp_win(cfg_data[WIN_W-1:0]);
        REG_MAX_WINDOW: max_window <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end else begin
      if (cmd.clr_norm) begin
        norm_pending  <= 1'b0;
        start_pending <= 1'b0;
      end
      if (div_done) begin
        case (sel_r)
          SEL_SEND:  send_seq    <= div_rem[SEQ_BITS-1:0];
          SEL_ACKED: acked_seq   <= div_rem[SEQ_BITS-1:0];
          SEL_HIGH:  highest_seq <= div_rem[SEQ_BITS-1:0];
          SEL_START: begin
            send_seq    <= div_rem[SEQ_BITS-1:0];
            acked_seq   <= div_rem[SEQ_BITS-1:0];
            highest_seq <= div_rem[SEQ_BITS-1:0];
          end
          default: ;
        endcase
      end
      if (cmd.update) begin
        case (func_r)
          FUNC_SEND: begin
            if (win_open) begin
              if (high_move) highest_seq <= end_r;
              send_seq  <= end_r;
              in_flight <= infl_add;
            end
          end
          FUNC_ACK: begin
            if (id_ok_r && in_win) begin
              cwnd      <= cwnd_grown;
              in_flight <= infl_sub;
              if (da > ds) send_seq <= ack_r;
              acked_seq <= ack_r;
            end
          end
          FUNC_TIMEOUT: begin
            ssthresh  <= cwnd >> 1;
            cwnd      <= WIN_W'(MSS);
            send_seq  <= send_rew;
            in_flight <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // request operands and divider results
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r  <= func;
      bytes_r <= bytes_clamped;
      ack_r   <= ack_number;
      id_ok_r <= peer_conn_id == expected_conn_id;
    end else if (div_done) begin
      case (sel_r)
        SEL_ACKN: ack_r    <= div_rem[SEQ_BITS-1:0];
        SEL_INFL: infl_mod <= div_rem[SEQ_BITS-1:0];
        SEL_END:  end_r    <= div_rem[SEQ_BITS-1:0];
        SEL_CA:   ca_inc   <= div_quo[CA_INC_W-1:0];
        default: ;
      endcase
    end
    if (cmd.div_start) sel_r <= cmd.div_sel;
    if (cmd.update) begin
      seg_seq_r <= (func_r == FUNC_SEND) ? send_seq : '0;
      retx_r    <= (func_r == FUNC_SEND) && win_open && (ds < dh);
      acc_r     <= (func_r == FUNC_ACK) && id_ok_r && in_win;
      cerr_r    <= (func_r == FUNC_ACK) && !id_ok_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      may_send          <= win_open;
      seg_seq           <= seg_seq_r;
      seg_is_retransmit <= retx_r;
      ack_accepted      <= acc_r;
      conn_error        <= cerr_r;
      cwnd_now          <= cwnd;
      ssthresh_now      <= ssthresh;
      in_flight_now     <= in_flight;
    end
  end

  always_comb begin
    stat.div_done      = div_done;
    stat.div_busy      = div_busy;
    stat.func          = func_r;
    stat.id_ok         = id_ok_r;
    stat.win_open      = win_open;
    stat.ack_in_win    = in_win;
    stat.slow_start    = slow_start;
    stat.norm_pending  = norm_pending;
    stat.start_pending = start_pending;
    stat.out_free      = !out_valid || !out_stall;
  end

endmodule

### hdl/cwc_ctrl.sv
module cwc_ctrl
  import cwc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t stat,
  output cmd_t    cmd
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0_0000_0000_0001,
    S_NSEND  = 13'b0_0000_0000_0010,
    S_NACKED = 13'b0_0000_0000_0100,
    S_NHIGH  = 13'b0_0000_0000_1000,
    S_DISP   = 13'b0_0000_0001_0000,
    S_ACKN   = 13'b0_0000_0010_0000,
    S_ACHK   = 13'b0_0000_0100_0000,
    S_INFL   = 13'b0_0000_1000_0000,
    S_END    = 13'b0_0001_0000_0000,
    S_CA     = 13'b0_0010_0000_0000,
    S_UPD    = 13'b0_0100_0000_0000,
    S_OUT    = 13'b0_1000_0000_0000,
    S_NSTART = 13'b1_0000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   op_run;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.div_sel   = SEL_SEND;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          if (stat.start_pending) state_next = S_NSTART;
          else state_next = stat.norm_pending ? S_NSEND : S_DISP;
        end
      end
      S_NSTART: begin
        cmd.div_sel   = SEL_START;
        cmd.div_start = !op_run;
        if (stat.div_done) state_next = S_NSEND;
      end
      S_NSEND: begin
        cmd.div_sel   = SEL_SEND;
        cmd.div_start = !op_run;
        if (stat.div_done) state_next = S_NACKED;
      end
      S_NACKED: begin
        cmd.div_sel   = SEL_ACKED;
        cmd.div_start = !op_run;
        if (stat.div_done) state_next = S_NHIGH;
      end
      S_NHIGH: begin
        cmd.div_sel   = SEL_HIGH;
        cmd.div_start = !op_run;
        if (stat.div_done) state_next = S_DISP;
      end
      S_DISP: begin
        cmd.clr_norm = 1'b1;
        case (stat.func)
          FUNC_SEND:    state_next = stat.win_open ? S_END : S_UPD;
          FUNC_ACK:     state_next = stat.id_ok ? S_ACKN : S_UPD;
          FUNC_TIMEOUT: state_next = S_INFL;
          default:      state_next = S_UPD;
        endcase
      end
      S_ACKN: begin
        cmd.div_sel   = SEL_ACKN;
        cmd.div_start = !op_run;
        if (stat.div_done) state_next = S_ACHK;
      end
      S_ACHK: begin
        state_next = (stat.ack_in_win && !stat.slow_start) ? S_CA : S_UPD;
      end
      S_INFL: begin
        cmd.div_sel   = SEL_INFL;
        cmd.div_start = !op_run;
        if (stat.div_done) state_next = S_UPD;
      end
      S_END: begin
        cmd.div_sel   = SEL_END;
        cmd.div_start = !op_run;
        if (stat.div_done) state_next = S_UPD;
      end
      S_CA: begin
        cmd.div_sel   = SEL_CA;
        cmd.div_start = !op_run;
        if (stat.div_done) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      op_run <= 1'b0;
    end else begin
      state <= state_next;
      if (stat.div_done) begin
        op_run <= 1'b0;
      end else if (cmd.div_start) begin
        op_run <= 1'b1;
      end
    end
  end

endmodule
